// ----- rtl/matinv_pkg.sv -----
// Shared constants for the 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
package matinv_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int NUM_ELEMS       = 9;

endpackage

// ----- rtl/matinv_det.sv -----
// Cofactor and determinant front end: four register stages.
`timescale 1ns / 1ps
module matinv_det #(
  parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic signed [ENTRY_WIDTH-1:0]   m_i   [matinv_pkg::NUM_ELEMS],
  output logic                            valid_o,
  output logic signed [2*ENTRY_WIDTH:0]   cof_o [matinv_pkg::NUM_ELEMS],
  output logic signed [3*ENTRY_WIDTH+2:0] det_o
);

  localparam int EW  = ENTRY_WIDTH;
  localparam int PW  = 2 * EW;
  localparam int CW  = 2 * EW + 1;
  localparam int PPW = 2 * EW + 1;
  localparam int DW  = 3 * EW + 3;
  localparam int NE  = matinv_pkg::NUM_ELEMS;

  logic [3:0]             v_q;
  logic signed [PW-1:0]   p_q   [NE];
  logic signed [PW-1:0]   n_q   [NE];
  logic signed [CW-1:0]   cof2_q[NE];
  logic signed [CW-1:0]   cof3_q[NE];
  logic signed [CW-1:0]   cof4_q[NE];
  logic signed [EW-1:0]   m1_q  [3];
  logic signed [EW-1:0]   m2_q  [3];
  logic signed [PPW-1:0]  lo_q  [3];
  logic signed [PPW-1:0]  hi_q  [3];
  logic signed [DW-1:0]   det_d;
  logic signed [DW-1:0]   det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  for (genvar g = 0; g < NE; g++) begin : g_cof
    localparam int I  = g / 3;
    localparam int J  = g % 3;
    localparam int R0 = (I == 0) ? 1 : 0;
    localparam int R1 = (I == 2) ? 1 : 2;
    localparam int C0 = (J == 0) ? 1 : 0;
    localparam int C1 = (J == 2) ? 1 : 2;
    localparam bit ODD = ((I + J) % 2) == 1;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        p_q[g]    <= m_i[R0*3+C0] * m_i[R1*3+C1];
        n_q[g]    <= m_i[R0*3+C1] * m_i[R1*3+C0];
        // odd positions take the minus sign of the checkerboard
        if (ODD) begin
          cof2_q[g] <= $signed({n_q[g][PW-1], n_q[g]}) - $signed({p_q[g][PW-1], p_q[g]});
        end else begin
          cof2_q[g] <= $signed({p_q[g][PW-1], p_q[g]}) - $signed({n_q[g][PW-1], n_q[g]});
        end
        cof3_q[g] <= cof2_q[g];
        cof4_q[g] <= cof3_q[g];
      end
    end
  end

  // split each first-row cofactor so no product exceeds entry by entry+1 bits
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        m1_q[j] <= m_i[j];
        m2_q[j] <= m1_q[j];
        lo_q[j] <= m2_q[j] * $signed({1'b0, cof2_q[j][EW-1:0]});
        hi_q[j] <= m2_q[j] * $signed(cof2_q[j][CW-1:EW]);
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d
            + ($signed({{(DW-PPW){hi_q[j][PPW-1]}}, hi_q[j]}) <<< EW)
            + $signed({{(DW-PPW){lo_q[j][PPW-1]}}, lo_q[j]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      det_q <= det_d;
    end
  end

  assign valid_o = v_q[3];
  assign cof_o   = cof4_q;
  assign det_o   = det_q;

endmodule

// ----- rtl/matinv_div.sv -----
// Nine-lane pipelined restoring divider with saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module matinv_div #(
  parameter int FRAC_BITS   = matinv_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic signed [2*ENTRY_WIDTH:0]   cof_i [matinv_pkg::NUM_ELEMS],
  input  logic signed [3*ENTRY_WIDTH+2:0] det_i,
  output logic                            valid_o,
  output logic signed [ENTRY_WIDTH-1:0]   r_o   [matinv_pkg::NUM_ELEMS],
  output logic                            singular_o
);

  localparam int EW = ENTRY_WIDTH;
  localparam int CW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int XW = (NW > DW + EW) ? NW : DW + EW;
  localparam int NE = matinv_pkg::NUM_ELEMS;
  localparam logic [EW-1:0] HALF = {1'b1, {(EW-1){1'b0}}};

  // prep stage
  logic              pv_q;
  logic [DW-1:0]     pdm_q;
  logic              psing_q;
  logic [NW-1:0]     pnum_q [NE];
  logic              pneg_q [NE];

  // step stages, index 0 is after the range check
  logic              v_q    [EW+1];
  logic [DW-1:0]     dm_q   [EW+1];
  logic              sing_q [EW+1];
  logic [NW-1:0]     rem_q  [EW+1][NE];
  logic [EW-1:0]     quo_q  [EW+1][NE];
  logic              big_q  [EW+1][NE];
  logic              neg_q  [EW+1][NE];

  logic              ov_q;
  logic              osing_q;
  logic [EW-1:0]     out_q  [NE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int s = 0; s <= EW; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv_i) begin
      pv_q   <= valid_i;
      v_q[0] <= pv_q;
      for (int s = 0; s < EW; s++) begin
        v_q[s+1] <= v_q[s];
      end
      ov_q <= v_q[EW];
    end
  end

  // take magnitudes and scale numerators by two fraction widths
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pdm_q   <= det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
      psing_q <= (det_i == '0);
      for (int e = 0; e < NE; e++) begin
        pnum_q[e] <= {(cof_i[e][CW-1] ? CW'(-cof_i[e]) : CW'(cof_i[e])),
                      {(2*FRAC_BITS){1'b0}}};
        pneg_q[e] <= cof_i[e][CW-1] ^ det_i[DW-1];
      end
    end
  end

  // flag quotients of 2^EW or more; they saturate regardless of later bits
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dm_q[0]   <= pdm_q;
      sing_q[0] <= psing_q;
      for (int e = 0; e < NE; e++) begin
        rem_q[0][e] <= pnum_q[e];
        quo_q[0][e] <= '0;
        neg_q[0][e] <= pneg_q[e];
        big_q[0][e] <= XW'(pnum_q[e]) >= (XW'(pdm_q) << EW);
      end
    end
  end

  for (genvar s = 0; s < EW; s++) begin : g_step
    localparam int K = EW - 1 - s;
    logic [XW-1:0] sh;
    logic [XW-1:0] diff [NE];
    logic          take [NE];

    always_comb begin
      sh = XW'(dm_q[s]) << K;
      for (int e = 0; e < NE; e++) begin
        diff[e] = XW'(rem_q[s][e]) - sh;
        take[e] = XW'(rem_q[s][e]) >= sh;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dm_q[s+1]   <= dm_q[s];
        sing_q[s+1] <= sing_q[s];
        for (int e = 0; e < NE; e++) begin
          rem_q[s+1][e] <= take[e] ? diff[e][NW-1:0] : rem_q[s][e];
          quo_q[s+1][e] <= quo_q[s][e] | ({{(EW-1){1'b0}}, take[e]} << K);
          big_q[s+1][e] <= big_q[s][e];
          neg_q[s+1][e] <= neg_q[s][e];
        end
      end
    end
  end

  // clamp to the signed range, apply the sign, zero on singular
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      osing_q <= sing_q[EW];
      for (int e = 0; e < NE; e++) begin
        logic [EW-1:0] lim;
        logic [EW-1:0] mag;
        lim = neg_q[EW][e] ? HALF : HALF - EW'(1);
        mag = (big_q[EW][e] || quo_q[EW][e] > lim) ? lim : quo_q[EW][e];
        if (sing_q[EW]) begin
          out_q[e] <= '0;
        end else begin
          out_q[e] <= neg_q[EW][e] ? -mag : mag;
        end
      end
    end
  end

  assign valid_o    = ov_q;
  assign singular_o = osing_q;
  for (genvar e = 0; e < NE; e++) begin : g_out
    assign r_o[e] = $signed(out_q[e]);
  end

endmodule

// ----- rtl/matrix_inverse_3x3.sv -----
// Top level of the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
// One 3x3 matrix of signed fixed-point entries enters per beat and leaves as
// its inverse (adjugate over determinant, quotient truncated toward zero,
// saturated to the entry range), one output beat per beat in, so a full
// matrix per clock is sustained while the output does not stall. Four stages
// form products, cofactors and the determinant, then a divider pipeline
// spends one stage per quotient bit plus range check, prep and output stages.
// A zero determinant gives all zero entries with singular_o set. The whole
// pipe holds while a finished beat waits at the output, so in_stall_o
// follows out_stall_i then.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS   = matinv_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_WIDTH = matinv_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [ENTRY_WIDTH-1:0] m00_i,
  input  logic signed [ENTRY_WIDTH-1:0] m01_i,
  input  logic signed [ENTRY_WIDTH-1:0] m02_i,
  input  logic signed [ENTRY_WIDTH-1:0] m10_i,
  input  logic signed [ENTRY_WIDTH-1:0] m11_i,
  input  logic signed [ENTRY_WIDTH-1:0] m12_i,
  input  logic signed [ENTRY_WIDTH-1:0] m20_i,
  input  logic signed [ENTRY_WIDTH-1:0] m21_i,
  input  logic signed [ENTRY_WIDTH-1:0] m22_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ENTRY_WIDTH-1:0] r00_o,
  output logic signed [ENTRY_WIDTH-1:0] r01_o,
  output logic signed [ENTRY_WIDTH-1:0] r02_o,
  output logic signed [ENTRY_WIDTH-1:0] r10_o,
  output logic signed [ENTRY_WIDTH-1:0] r11_o,
  output logic signed [ENTRY_WIDTH-1:0] r12_o,
  output logic signed [ENTRY_WIDTH-1:0] r20_o,
  output logic signed [ENTRY_WIDTH-1:0] r21_o,
  output logic signed [ENTRY_WIDTH-1:0] r22_o,
  output logic                          singular_o
);

  localparam int EW = ENTRY_WIDTH;
  localparam int NE = matinv_pkg::NUM_ELEMS;

  logic                   adv;
  logic signed [EW-1:0]   m    [NE];
  logic                   det_valid;
  logic signed [2*EW:0]   cof  [NE];
  logic signed [3*EW+2:0] det;
  logic signed [EW-1:0]   r    [NE];

  // advance every stage unless a finished beat is held at the output
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign m[0] = m00_i;
  assign m[1] = m01_i;
  assign m[2] = m02_i;
  assign m[3] = m10_i;
  assign m[4] = m11_i;
  assign m[5] = m12_i;
  assign m[6] = m20_i;
  assign m[7] = m21_i;
  assign m[8] = m22_i;

  // cofactors and determinant
  matinv_det #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(in_valid_i),
    .m_i    (m),
    .valid_o(det_valid),
    .cof_o  (cof),
    .det_o  (det)
  );

  // transposed cofactor over determinant: r[i][j] uses cofactor (j,i)
  logic signed [2*EW:0] cof_t [NE];
  for (genvar g = 0; g < NE; g++) begin : g_tr
    assign cof_t[g] = cof[(g % 3) * 3 + g / 3];
  end

  matinv_div #(
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (det_valid),
    .cof_i     (cof_t),
    .det_i     (det),
    .valid_o   (out_valid_o),
    .r_o       (r),
    .singular_o(singular_o)
  );

  assign r00_o = r[0];
  assign r01_o = r[1];
  assign r02_o = r[2];
  assign r10_o = r[3];
  assign r11_o = r[4];
  assign r12_o = r[5];
  assign r20_o = r[6];
  assign r21_o = r[7];
  assign r22_o = r[8];

endmodule

// ----- tb/matrix_inverse_3x3_test.sv -----
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
// Stream matrices into the block and check every inverse beat against an
// exact wide-integer predictor.
//
// - The predictor forms the adjugate and the determinant in 192-bit signed
//   integers.
// - It divides each cofactor, scaled by 2^(2*FRAC), by the determinant.
//   SystemVerilog division truncates toward zero, as the block does.
// - It then clamps the quotient to the entry range.
//
// An initial block fills the queue of pending matrices in four phases, each
// with its own idle mix on the two handshakes. A negedge driver feeds the
// block from that queue. A posedge monitor checks each output beat against
// the oldest expected inverse.
module matrix_inverse_3x3_test;

  localparam int W        = matinv_pkg::ENTRY_WIDTH_DEF;
  localparam int NE       = matinv_pkg::NUM_ELEMS;
  localparam int SCALE    = 2 * matinv_pkg::FRAC_BITS_DEF;
  localparam int ONE      = 1 << matinv_pkg::FRAC_BITS_DEF;
  localparam int LIMIT    = 400000;
  localparam int DRAIN    = 3 * (W + 7);
  localparam int PER_PHASE = 100;

  typedef logic signed [W-1:0] entry_t;
  typedef logic signed [191:0] wide_t;
  typedef struct {
    entry_t e[NE];
  } matrix_t;
  typedef struct {
    entry_t r[NE];
    logic   singular;
  } inverse_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    out_stall = 1'b0;
  logic    in_stall, out_valid, singular;
  entry_t  m[NE] = '{default: '0};
  entry_t  r[NE];

  matrix_t  pending_mats[$];
  inverse_t expected_invs[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       cycles = 0;
  int       errors = 0;
  int       checked = 0;
  int       singular_seen = 0;
  string    field_names[NE] =
    '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  matrix_inverse_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .m00_i      (m[0]),
    .m01_i      (m[1]),
    .m02_i      (m[2]),
    .m10_i      (m[3]),
    .m11_i      (m[4]),
    .m12_i      (m[5]),
    .m20_i      (m[6]),
    .m21_i      (m[7]),
    .m22_i      (m[8]),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .r00_o      (r[0]),
    .r01_o      (r[1]),
    .r02_o      (r[2]),
    .r10_o      (r[3]),
    .r11_o      (r[4]),
    .r12_o      (r[5]),
    .r20_o      (r[6]),
    .r21_o      (r[7]),
    .r22_o      (r[8]),
    .singular_o (singular)
  );

  // Exact inverse: adjugate over determinant, truncated toward zero, then
  // saturated to the entry range.
  function automatic inverse_t predict_inverse(matrix_t mat);
    wide_t    a[3][3];
    wide_t    cof[3][3];
    wide_t    det, num, quo;
    wide_t    hi, lo;
    inverse_t res;
    int       r0, r1, c0, c1;
    hi = wide_t'({1'b0, {(W-1){1'b1}}});
    lo = -hi - 1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = mat.e[i*3+j];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        cof[i][j] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
        if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
      end
    end
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    res.singular = (det == 0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (res.singular) begin
          res.r[i*3+j] = '0;
        end else begin
          // transposed cofactor: entry (i,j) of the inverse uses C[j][i]
          num = cof[j][i] <<< SCALE;
          quo = num / det;
          if (quo > hi) quo = hi;
          if (quo < lo) quo = lo;
          res.r[i*3+j] = entry_t'(quo);
        end
      end
    end
    return res;
  endfunction

  function automatic entry_t rand_entry();
    entry_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom();                                           // full range
      1: v = $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      default: v = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE; // well scaled
    endcase
    return v;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mat;
    int      src, dst;
    foreach (mat.e[k]) mat.e[k] = rand_entry();
    // make roughly one in eight singular by copying a row
    if ($urandom_range(0, 7) == 0) begin
      src = $urandom_range(0, 2);
      dst = (src + 1 + $urandom_range(0, 1)) % 3;
      for (int c = 0; c < 3; c++) mat.e[dst*3+c] = mat.e[src*3+c];
    end
    return mat;
  endfunction

  function automatic matrix_t make_matrix(entry_t a0, entry_t a1, entry_t a2,
                                          entry_t a3, entry_t a4, entry_t a5,
                                          entry_t a6, entry_t a7, entry_t a8);
    matrix_t mat;
    mat.e = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    return mat;
  endfunction

  // Append a matrix at the tail of the pending queue.
  function automatic void enqueue_matrix(matrix_t mat);
    pending_mats.insert(pending_mats.size(), mat);
  endfunction

  // Driver: present a new beat at the falling edge once the last one is taken.
  logic took = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      took   <= in_valid && !in_stall;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!in_valid || took) begin
        if (pending_mats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          matrix_t mat;
          mat = pending_mats.pop_front();
          foreach (m[k]) m[k] <= mat.e[k];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      matrix_t mat;
      foreach (m[k]) mat.e[k] = m[k];
      expected_invs.insert(expected_invs.size(), predict_inverse(mat));
    end
    if (rst_ni && out_valid && !out_stall) begin
      inverse_t want;
      if (expected_invs.size() == 0) begin
        $error("output beat with no matrix outstanding");
        errors++;
      end else begin
        want = expected_invs.pop_front();
        checked++;
        if (want.singular) singular_seen++;
        foreach (r[k]) begin
          if (r[k] !== want.r[k]) begin
            $error("%s: expected %0d, got %0d", field_names[k], want.r[k], r[k]);
            errors++;
          end
        end
        if (singular !== want.singular) begin
          $error("singular: expected %0b, got %0b", want.singular, singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold until every queued matrix is sent and every inverse has come back.
  task automatic wait_drained();
    while (pending_mats.size() > 0 || in_valid || expected_invs.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    entry_t maxv, minv, raw1;
    int     send_pct[4] = '{0, 76, 0, 25};
    int     recv_pct[4] = '{0, 0, 76, 25};
    maxv = {1'b0, {(W-1){1'b1}}};
    minv = {1'b1, {(W-1){1'b0}}};
    raw1 = 1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, scaling, transposition, singular and saturation.
    enqueue_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    enqueue_matrix(make_matrix(2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2));
    enqueue_matrix(make_matrix(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 0, 0, ONE));
    enqueue_matrix(make_matrix(2*ONE, ONE, 0, -ONE, 3*ONE, 5*ONE,
                               7*ONE, -2*ONE, ONE));
    enqueue_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_matrix(make_matrix(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE,
                               7*ONE, 8*ONE, 9*ONE));
    enqueue_matrix(make_matrix(raw1, 0, 0, 0, raw1, 0, 0, 0, raw1));
    enqueue_matrix(make_matrix(-raw1, 0, 0, 0, raw1, 0, 0, 0, raw1));
    enqueue_matrix(make_matrix(maxv, 0, 0, 0, maxv, 0, 0, 0, maxv));
    enqueue_matrix(make_matrix(minv, 0, 0, 0, minv, 0, 0, 0, minv));
    enqueue_matrix(make_matrix(minv, minv, minv, minv, minv, minv,
                               minv, minv, minv));
    enqueue_matrix(make_matrix(maxv, minv, maxv, minv, maxv, maxv,
                               maxv, maxv, minv));
    enqueue_matrix(make_matrix(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
    enqueue_matrix(make_matrix(-1, -1, 0, 0, -1, -1, -1, 0, -1));
    enqueue_matrix(make_matrix(3, 0, 0, 0, 1, 0, 0, 0, ONE));

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int n = 0; n < PER_PHASE; n++) enqueue_matrix(rand_matrix());
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN) @(posedge clk_i);

    if (expected_invs.size() != 0) begin
      $error("%0d inverses never arrived", expected_invs.size());
      errors++;
    end
    $display("checked %0d inverse beats (%0d singular) over four handshake mixes",
             checked, singular_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/matinv_pkg.sv
rtl/matinv_det.sv
rtl/matinv_div.sv
rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_test.sv
